>>> hw/rtl/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude unit.
// No dependencies.
package sem_pkg;

  localparam int GRAY_W     = 16;
  localparam int MAG_W      = 8;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RED_WEIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_WEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_WEIGHT  = 3'd4;

  localparam int RES_DEPTH = 8;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  typedef struct packed {
    logic             has0;
    logic [MAG_W-1:0] mag0;
    logic             has1;
    logic [MAG_W-1:0] mag1;
    logic             last;
  } res_pair_t;

endpackage

>>> hw/rtl/sobel_edge_magnitude_unit.sv
// Sobel edge magnitude unit: RGB to gray, two line stores, 3x3 window, |Gx|+|Gy|.
// Throughput one item per cycle while in_stall is low; results leave one per cycle
// at the output queue while out_stall is low, once through stages 1, 2 and 3 and the queue.
// Line stores are one registered-read memory; each item reads and writes back its column.
// Reset clears counters, window and queue; line store contents stay undefined until written.
// Depends on sem_pkg, sem_line_store, sem_result_fifo.
module sobel_edge_magnitude_unit #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_kind,
  input  logic [7:0]                     in_red,
  input  logic [7:0]                     in_green,
  input  logic [7:0]                     in_blue,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [sem_pkg::MAG_W-1:0]      out_magnitude,
  output logic                           out_last
);
  import sem_pkg::*;

  localparam int RST_DIM    = 64;
  localparam int WIDTH_CAP  = (MAX_WIDTH > RST_DIM) ? MAX_WIDTH : RST_DIM;
  localparam int HEIGHT_CAP = (MAX_HEIGHT > RST_DIM) ? MAX_HEIGHT : RST_DIM;
  localparam int WID_W      = $clog2(WIDTH_CAP + 1);
  localparam int COL_W      = $clog2(WIDTH_CAP);
  localparam int HGT_W      = $clog2(HEIGHT_CAP + 1);
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int WGT_W      = 9;
  localparam int PROD_W     = 8 + WGT_W;
  localparam int SUM_W      = PROD_W + 2;

  localparam logic [WGT_W-1:0] WGT_MAX   = 9'd256;
  localparam logic [WGT_W-1:0] RST_RED   = 9'd77;
  localparam logic [WGT_W-1:0] RST_GREEN = 9'd150;
  localparam logic [WGT_W-1:0] RST_BLUE  = 9'd29;
  localparam logic             KIND_PIXEL = 1'b0;

  typedef logic [8:0][GRAY_W-1:0] win_t;

  typedef struct packed {
    logic [GRAY_W+1:0]        smt;
    logic [GRAY_W+1:0]        smb;
    logic signed [GRAY_W:0]   dt;
    logic signed [GRAY_W:0]   dm;
    logic signed [GRAY_W:0]   db;
  } part_t;

  function automatic part_t sob_part(input win_t w);
    part_t p;
    p.smt = (GRAY_W+2)'(w[0]) + {1'b0, w[1], 1'b0} + (GRAY_W+2)'(w[2]);
    p.smb = (GRAY_W+2)'(w[6]) + {1'b0, w[7], 1'b0} + (GRAY_W+2)'(w[8]);
    p.dt  = $signed({1'b0, w[2]}) - $signed({1'b0, w[0]});
    p.dm  = $signed({1'b0, w[5]}) - $signed({1'b0, w[3]});
    p.db  = $signed({1'b0, w[8]}) - $signed({1'b0, w[6]});
    return p;
  endfunction

  function automatic logic [MAG_W-1:0] sob_mag(input part_t p);
    logic signed [GRAY_W+2:0] gx;
    logic signed [GRAY_W+2:0] gy;
    logic signed [GRAY_W+2:0] ngx;
    logic signed [GRAY_W+2:0] ngy;
    logic [GRAY_W+1:0]        ax;
    logic [GRAY_W+1:0]        ay;
    logic [GRAY_W+2:0]        s;
    gx  = $signed({1'b0, p.smb}) - $signed({1'b0, p.smt});
    gy  = $signed({{2{p.dt[GRAY_W]}}, p.dt}) + $signed({p.dm[GRAY_W], p.dm, 1'b0})
        + $signed({{2{p.db[GRAY_W]}}, p.db});
    ngx = -gx;
    ngy = -gy;
    ax  = gx[GRAY_W+2] ? ngx[GRAY_W+1:0] : gx[GRAY_W+1:0];
    ay  = gy[GRAY_W+2] ? ngy[GRAY_W+1:0] : gy[GRAY_W+1:0];
    s   = (GRAY_W+3)'(ax) + (GRAY_W+3)'(ay);
    return s[GRAY_W+2] ? {MAG_W{1'b1}} : s[GRAY_W+1:10];
  endfunction

  // configuration
  logic [WID_W-1:0] width_r;
  logic [HGT_W-1:0] height_r;
  logic [WGT_W-1:0] red_w_r, green_w_r, blue_w_r;
  logic [WGT_W-1:0] wgt_nxt;

  assign wgt_nxt = (cfg_wdata[WGT_W-1:0] > WGT_MAX) ? WGT_MAX : cfg_wdata[WGT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= WID_W'(RST_DIM);
      height_r  <= HGT_W'(RST_DIM);
      red_w_r   <= RST_RED;
      green_w_r <= RST_GREEN;
      blue_w_r  <= RST_BLUE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          if (cfg_wdata == '0) begin
            width_r <= WID_W'(1);
          end else if (int'(cfg_wdata) > MAX_WIDTH) begin
            width_r <= WID_W'(MAX_WIDTH);
          end else begin
            width_r <= WID_W'(cfg_wdata);
          end
        end
        REG_IMAGE_HEIGHT: begin
          if (cfg_wdata == '0) begin
            height_r <= HGT_W'(1);
          end else if (int'(cfg_wdata) > MAX_HEIGHT) begin
            height_r <= HGT_W'(MAX_HEIGHT);
          end else begin
            height_r <= HGT_W'(cfg_wdata);
          end
        end
        REG_RED_WEIGHT:   red_w_r   <= wgt_nxt;
        REG_GREEN_WEIGHT: green_w_r <= wgt_nxt;
        REG_BLUE_WEIGHT:  blue_w_r  <= wgt_nxt;
        default: ;
      endcase
    end
  end

  // stage 0: accept, position, products
  logic [COL_W-1:0] col_cnt_r, drain_cnt_r;
  logic [HGT_W-1:0] row_cnt_r;
  logic             draining, active, in_acc, go, last_col, in_range;
  logic [COL_W-1:0] cur_col;
  logic [WID_W-1:0] col_p1;
  logic [1:0]       inflight;
  logic [RES_CNT_W-1:0] res_count;

  logic             s1_v_r, s2_v_r, s3_v_r;

  assign draining = row_cnt_r >= height_r;
  assign active   = draining || (in_kind == KIND_PIXEL);
  assign cur_col  = draining ? drain_cnt_r : col_cnt_r;
  assign col_p1   = WID_W'(cur_col) + WID_W'(1);
  assign last_col = col_p1 >= width_r;
  assign in_range = WID_W'(cur_col) < WID_W'(MAX_WIDTH);
  assign inflight = 2'(s1_v_r) + 2'(s2_v_r) + 2'(s3_v_r);
  assign in_stall = ((RES_CNT_W+1)'(res_count) + (RES_CNT_W+1)'(inflight))
                    >= (RES_CNT_W+1)'(RES_DEPTH);
  assign in_acc   = in_valid && !in_stall;
  assign go       = in_acc && active;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      drain_cnt_r <= '0;
    end else if (go) begin
      if (last_col) begin
        col_cnt_r <= '0;
        if (draining) begin
          row_cnt_r   <= '0;
          drain_cnt_r <= '0;
        end else begin
          row_cnt_r <= row_cnt_r + HGT_W'(1);
        end
      end else if (draining) begin
        drain_cnt_r <= col_p1[COL_W-1:0];
      end else begin
        col_cnt_r <= col_p1[COL_W-1:0];
      end
    end
  end

  logic [ADDR_W-1:0] s1_addr_r;
  logic              s1_inr_r, s1_ge1_r, s1_ge2_r, s1_col0_r, s1_e0_r, s1_e1_r, s1_last_r;
  logic [PROD_W-1:0] s1_pr_r, s1_pg_r, s1_pb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      s1_addr_r <= cur_col[ADDR_W-1:0];
      s1_inr_r  <= in_range;
      s1_ge1_r  <= row_cnt_r >= HGT_W'(1);
      s1_ge2_r  <= row_cnt_r >= HGT_W'(2);
      s1_col0_r <= cur_col == '0;
      s1_e0_r   <= (row_cnt_r >= HGT_W'(1)) && (cur_col != '0);
      s1_e1_r   <= last_col && (row_cnt_r >= HGT_W'(1));
      s1_last_r <= draining;
      s1_pr_r   <= draining ? '0 : PROD_W'(in_red) * PROD_W'(red_w_r);
      s1_pg_r   <= draining ? '0 : PROD_W'(in_green) * PROD_W'(green_w_r);
      s1_pb_r   <= draining ? '0 : PROD_W'(in_blue) * PROD_W'(blue_w_r);
    end
  end

  // stage 1: gray, line store write-back, window shift
  logic [2*GRAY_W-1:0] line_rd;
  logic [2*GRAY_W-1:0] line_wr;
  logic [GRAY_W-1:0]   top, mid, gray;
  logic [SUM_W-1:0]    gsum;
  win_t                win_r, win_nxt;

  sem_line_store #(
    .ADDR_W (ADDR_W)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (go),
    .rd_addr (cur_col[ADDR_W-1:0]),
    .rd_data (line_rd),
    .wr_en   (s1_v_r && s1_inr_r),
    .wr_addr (s1_addr_r),
    .wr_data (line_wr)
  );

  assign gsum    = SUM_W'(s1_pr_r) + SUM_W'(s1_pg_r) + SUM_W'(s1_pb_r);
  assign gray    = (|gsum[SUM_W-1:GRAY_W]) ? {GRAY_W{1'b1}} : gsum[GRAY_W-1:0];
  assign top     = (s1_ge2_r && s1_inr_r) ? line_rd[2*GRAY_W-1:GRAY_W] : '0;
  assign mid     = (s1_ge1_r && s1_inr_r) ? line_rd[GRAY_W-1:0] : '0;
  assign line_wr = {line_rd[GRAY_W-1:0], gray};

  always_comb begin
    if (s1_col0_r) begin
      win_nxt = '0;
    end else begin
      win_nxt    = win_r;
      win_nxt[0] = win_r[1];
      win_nxt[1] = win_r[2];
      win_nxt[3] = win_r[4];
      win_nxt[4] = win_r[5];
      win_nxt[6] = win_r[7];
      win_nxt[7] = win_r[8];
    end
    win_nxt[2] = top;
    win_nxt[5] = mid;
    win_nxt[8] = gray;
  end

  logic s2_e0_r, s2_e1_r, s2_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
      if (s1_v_r) begin
        win_r <= win_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_e0_r   <= s1_e0_r;
    s2_e1_r   <= s1_e1_r;
    s2_last_r <= s1_last_r;
  end

  // stage 2: kernel partial sums for the window and the right-edge window
  win_t  edge_win;
  part_t s3_main_r, s3_edge_r;
  logic  s3_e0_r, s3_e1_r, s3_last_r;

  always_comb begin
    edge_win    = '0;
    edge_win[0] = win_r[1];
    edge_win[1] = win_r[2];
    edge_win[3] = win_r[4];
    edge_win[4] = win_r[5];
    edge_win[6] = win_r[7];
    edge_win[7] = win_r[8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_main_r <= sob_part(win_r);
    s3_edge_r <= sob_part(edge_win);
    s3_e0_r   <= s2_e0_r;
    s3_e1_r   <= s2_e1_r;
    s3_last_r <= s2_last_r;
  end

  // stage 3: magnitudes into the result queue
  res_pair_t res_data;
  logic      res_push;

  assign res_push      = s3_v_r && (s3_e0_r || s3_e1_r);
  assign res_data.has0 = s3_e0_r;
  assign res_data.mag0 = sob_mag(s3_main_r);
  assign res_data.has1 = s3_e1_r;
  assign res_data.mag1 = sob_mag(s3_edge_r);
  assign res_data.last = s3_last_r;

  sem_result_fifo u_result_fifo (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (res_push),
    .push_data     (res_data),
    .occupancy     (res_count),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_magnitude (out_magnitude),
    .out_last      (out_last)
  );

  a_queue_credit: assert property (@(posedge clk) disable iff (!rst_n)
    ((RES_CNT_W+1)'(res_count) + (RES_CNT_W+1)'(inflight)) <= (RES_CNT_W+1)'(RES_DEPTH))
    else $error("result queue credit exceeded");

  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (go && draining && last_col) |=>
      (row_cnt_r == '0 && col_cnt_r == '0 && drain_cnt_r == '0))
    else $error("counters not cleared at frame end");

endmodule

>>> hw/rtl/sem_line_store.sv
// Line store memory holding the two previous rows of gray values per column.
// One read and one write port, registered read, read-during-write forwarding.
// Depends on sem_pkg.
module sem_line_store #(
  parameter int ADDR_W = 11
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [2*sem_pkg::GRAY_W-1:0] rd_data,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [2*sem_pkg::GRAY_W-1:0] wr_data
);
  import sem_pkg::*;

  localparam int DEPTH = 2 ** ADDR_W;

  logic [2*GRAY_W-1:0] line_mem [DEPTH];
  logic [2*GRAY_W-1:0] rd_q_r;
  logic [2*GRAY_W-1:0] byp_data_r;
  logic                byp_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= line_mem[rd_addr];
    end
    byp_r      <= rd_en && wr_en && (rd_addr == wr_addr);
    byp_data_r <= wr_data;
  end

  assign rd_data = byp_r ? byp_data_r : rd_q_r;

endmodule

>>> hw/rtl/sem_result_fifo.sv
// Result queue: entries hold up to two magnitudes and are popped one at a time.
// Depends on sem_pkg.
module sem_result_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  sem_pkg::res_pair_t            push_data,
  output logic [sem_pkg::RES_CNT_W-1:0] occupancy,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sem_pkg::MAG_W-1:0]     out_magnitude,
  output logic                          out_last
);
  import sem_pkg::*;

  res_pair_t              queue_r [RES_DEPTH];
  logic [RES_PTR_W-1:0]   wr_ptr_r;
  logic [RES_PTR_W-1:0]   rd_ptr_r;
  logic [RES_CNT_W-1:0]   cnt_r;
  logic                   half_r;
  res_pair_t              head;
  logic                   sel_first;
  logic                   xfer;
  logic                   pop;

  assign head      = queue_r[rd_ptr_r];
  assign out_valid = (cnt_r != '0);
  assign sel_first = head.has0 && !half_r;
  assign xfer      = out_valid && !out_stall;
  assign pop       = xfer && !(sel_first && head.has1);

  assign out_magnitude = sel_first ? head.mag0 : head.mag1;
  assign out_last      = sel_first ? 1'b0 : head.last;
  assign occupancy     = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      half_r   <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + RES_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + RES_PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + RES_CNT_W'(1);
      end else if (!push && pop) begin
        cnt_r <= cnt_r - RES_CNT_W'(1);
      end
      if (xfer) begin
        half_r <= sel_first && head.has1;
      end
    end
  end

endmodule

>>> tb/sv/tb_sobel_edge_magnitude_unit.sv
// Testbench for sobel_edge_magnitude_unit: random RGB frames with stalls, early drain noise,
// geometry changes mid-frame and a long receiver hold-off, checked against a scoreboard.
// Depends on sem_pkg and sobel_edge_magnitude_unit.
`timescale 1ns / 1ps

class edge_scoreboard;
  localparam int MAX_DIM = 2048;

  typedef struct packed {
    logic [sem_pkg::MAG_W-1:0] magnitude;
    logic                      last;
  } edge_result_t;

  int unsigned width_eff, height_eff, red_w, green_w, blue_w;
  logic [sem_pkg::GRAY_W-1:0] upper_line [MAX_DIM];
  logic [sem_pkg::GRAY_W-1:0] lower_line [MAX_DIM];
  int unsigned win [9];
  int unsigned col_cnt, row_cnt, drain_cnt;
  bit frame_done;
  edge_result_t expected_edges [$];
  int unsigned errors, results_seen;

  function new();
    width_eff  = 64;
    height_eff = 64;
    red_w      = 77;
    green_w    = 150;
    blue_w     = 29;
    foreach (upper_line[i]) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
    foreach (win[i]) win[i] = 0;
    col_cnt    = 0;
    row_cnt    = 0;
    drain_cnt  = 0;
    frame_done = 1'b0;
    errors     = 0;
    results_seen = 0;
  endfunction

  function void write_reg(logic [sem_pkg::CFG_IDX_W-1:0] idx, logic [sem_pkg::CFG_DATA_W-1:0] val);
    int unsigned v, wv;
    v  = val;
    wv = val & 12'h1FF;
    if (wv > 256) wv = 256;
    case (idx)
      sem_pkg::REG_IMAGE_WIDTH:  width_eff  = (v < 1) ? 1 : ((v > MAX_DIM) ? MAX_DIM : v);
      sem_pkg::REG_IMAGE_HEIGHT: height_eff = (v < 1) ? 1 : ((v > MAX_DIM) ? MAX_DIM : v);
      sem_pkg::REG_RED_WEIGHT:   red_w   = wv;
      sem_pkg::REG_GREEN_WEIGHT: green_w = wv;
      sem_pkg::REG_BLUE_WEIGHT:  blue_w  = wv;
      default: ;
    endcase
  endfunction

  function bit in_drain();
    return row_cnt >= height_eff;
  endfunction

  function int unsigned pending();
    return expected_edges.size();
  endfunction

  function logic [sem_pkg::MAG_W-1:0] sobel_mag(int unsigned w [9]);
    longint smt, smb, dt, dm, db, gx, gy, sum;
    smt = longint'(w[0]) + 2 * longint'(w[1]) + longint'(w[2]);
    smb = longint'(w[6]) + 2 * longint'(w[7]) + longint'(w[8]);
    dt  = longint'(w[2]) - longint'(w[0]);
    dm  = longint'(w[5]) - longint'(w[3]);
    db  = longint'(w[8]) - longint'(w[6]);
    gx  = smb - smt;
    gy  = dt + 2 * dm + db;
    if (gx < 0) gx = -gx;
    if (gy < 0) gy = -gy;
    sum = (gx + gy) >>> 10;
    return (sum > 255) ? 8'd255 : sum[7:0];
  endfunction

  function void expect_edge(logic [sem_pkg::MAG_W-1:0] mag, logic last);
    edge_result_t res;
    res.magnitude = mag;
    res.last      = last;
    expected_edges.push_back(res);
  endfunction

  // Returns 1 when the transaction changed state, 0 for an ignored early drain tick.
  function bit accept_item(logic kind, logic [7:0] red, logic [7:0] green, logic [7:0] blue);
    int unsigned row, col, gray, top, mid, s;
    int unsigned border_win [9];
    bit draining;
    int i;
    row      = row_cnt;
    draining = row >= height_eff;
    top      = 0;
    mid      = 0;
    if (!draining) begin
      if (kind) return 1'b0;
      s    = red * red_w + green * green_w + blue * blue_w;
      gray = (s > 65535) ? 65535 : s;
      col  = col_cnt;
    end else begin
      gray = 0;
      col  = drain_cnt;
    end
    if (col < MAX_DIM) begin
      if (row >= 2) top = upper_line[col];
      if (row >= 1) mid = lower_line[col];
      upper_line[col] = lower_line[col];
      lower_line[col] = gray[15:0];
    end
    if (col == 0) foreach (win[k]) win[k] = 0;
    for (i = 0; i < 3; i++) begin
      win[i*3]   = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = gray;
    if (row >= 1 && col >= 1) expect_edge(sobel_mag(win), 1'b0);
    if (col + 1 >= width_eff) begin
      for (i = 0; i < 3; i++) begin
        border_win[i*3]   = win[i*3+1];
        border_win[i*3+1] = win[i*3+2];
        border_win[i*3+2] = 0;
      end
      if (row >= 1) expect_edge(sobel_mag(border_win), draining);
      if (draining) begin
        row_cnt    = 0;
        col_cnt    = 0;
        drain_cnt  = 0;
        foreach (win[k]) win[k] = 0;
        frame_done = 1'b1;
      end else begin
        col_cnt = 0;
        row_cnt = row + 1;
      end
    end else if (draining) begin
      drain_cnt = col + 1;
    end else begin
      col_cnt = col + 1;
    end
    return 1'b1;
  endfunction

  task report(string msg);
    if (errors < 200) $display("mismatch at %0t: result %0d: %s", $time, results_seen, msg);
    errors++;
  endtask

  task check_result(logic [sem_pkg::MAG_W-1:0] mag, logic last);
    edge_result_t want;
    if (expected_edges.size() == 0) begin
      report($sformatf("unexpected transaction, magnitude %0d last %0b", mag, last));
    end else begin
      want = expected_edges.pop_front();
      if (mag !== want.magnitude)
        report($sformatf("magnitude %0d, predicted %0d", mag, want.magnitude));
      if (last !== want.last)
        report($sformatf("last %0b, predicted %0b", last, want.last));
    end
    results_seen++;
  endtask
endclass

module tb_sobel_edge_magnitude_unit;
  import sem_pkg::*;

  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 1850;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_kind;
  logic [7:0]            in_red;
  logic [7:0]            in_green;
  logic [7:0]            in_blue;
  logic                  out_valid;
  logic                  out_stall;
  logic [MAG_W-1:0]      out_magnitude;
  logic                  out_last;

  edge_scoreboard sb;
  int unsigned    burst_left = 0;
  int unsigned    items_used = 0;
  bit             hold_req = 1'b0;

  sobel_edge_magnitude_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_magnitude (out_magnitude),
    .out_last      (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_magnitude, out_last);
  end

  initial begin : receiver
    int unsigned mode, span, tick;
    out_stall = 1'b0;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 300);
      repeat (span) begin
        @(negedge clk);
        if (hold_req) begin
          hold_req = 1'b0;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk);
        end
        tick++;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((tick % 5) < 2);
        endcase
      end
    end
  end

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int unsigned pick_weight();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 256;
      2:       return $urandom_range(257, 4095);
      3:       return $urandom_range(0, 16);
      default: return $urandom_range(0, 256);
    endcase
  endfunction

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.write_reg(idx, val[CFG_DATA_W-1:0]);
  endtask

  task automatic configure(int unsigned w, int unsigned h, int unsigned rw, int unsigned gw,
                           int unsigned bw);
    write_cfg(REG_IMAGE_WIDTH, w);
    write_cfg(REG_IMAGE_HEIGHT, h);
    write_cfg(REG_RED_WEIGHT, rw);
    write_cfg(REG_GREEN_WEIGHT, gw);
    write_cfg(REG_BLUE_WEIGHT, bw);
  endtask

  task automatic send_item(logic kind, logic [7:0] red, logic [7:0] green, logic [7:0] blue);
    int unsigned gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(40, 200);
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 16);
        gap = $urandom_range(0, 6);
      end
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_red   <= red;
    in_green <= green;
    in_blue  <= blue;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (sb.accept_item(kind, red, green, blue)) items_used++;
  endtask

  task automatic run_frame();
    logic kind;
    sb.frame_done = 1'b0;
    while (!sb.frame_done) begin
      if (sb.in_drain()) kind = $urandom_range(0, 1);
      else kind = ($urandom_range(0, 15) == 0);
      send_item(kind, pick_channel(), pick_channel(), pick_channel());
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned phase, frames, w, h;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_kind   = 1'b0;
    in_red    = '0;
    in_green  = '0;
    in_blue   = '0;
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Saturated gray, full-contrast checkerboard, early drain and pixel during drain.
    configure(3, 2, 256, 256, 256);
    send_item(1'b1, 8'd255, 8'd255, 8'd255);
    send_item(1'b0, 8'd255, 8'd255, 8'd255);
    send_item(1'b0, 8'd0, 8'd0, 8'd0);
    send_item(1'b0, 8'd255, 8'd255, 8'd255);
    send_item(1'b0, 8'd0, 8'd0, 8'd0);
    send_item(1'b0, 8'd255, 8'd255, 8'd255);
    send_item(1'b0, 8'd0, 8'd0, 8'd0);
    send_item(1'b1, 8'd0, 8'd0, 8'd0);
    send_item(1'b0, 8'd255, 8'd255, 8'd255);
    send_item(1'b1, 8'd0, 8'd0, 8'd0);
    wait_idle();

    // Narrow width mid-row, then height mid-frame.
    configure(4, 3, 511, 0, 300);
    send_item(1'b0, 8'd255, 8'd0, 8'd0);
    send_item(1'b0, 8'd0, 8'd0, 8'd255);
    send_item(1'b0, 8'd128, 8'd17, 8'd1);
    send_item(1'b0, 8'd255, 8'd255, 8'd255);
    send_item(1'b0, 8'd0, 8'd255, 8'd0);
    send_item(1'b0, 8'd200, 8'd0, 8'd100);
    wait_idle();
    write_cfg(REG_IMAGE_WIDTH, 2);
    send_item(1'b0, 8'd1, 8'd2, 8'd3);
    wait_idle();
    write_cfg(REG_IMAGE_HEIGHT, 2);
    run_frame();
    wait_idle();

    items_used = 0;
    phase = 0;
    while (items_used < RANDOM_ITEMS) begin
      frames = $urandom_range(1, 3);
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 8);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 6);
      case (phase)
        1: begin
          w = 16;
          h = 8;
          frames = 1;
        end
        2: begin
          w = 120;
          h = 4;
          frames = 1;
        end
        5: begin
          w = 0;
          h = 200;
          frames = 1;
        end
        default: ;
      endcase
      configure(w, h, pick_weight(), pick_weight(), pick_weight());
      if (phase == 1) hold_req = 1'b1;
      repeat (frames) run_frame();
      wait_idle();
      phase++;
    end

    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
